[rtl/isolation_forest_leaf_code_packer_macros.svh]
// Assertion macros shared by the leaf code packer modules.
`ifndef ISOLATION_FOREST_LEAF_CODE_PACKER_MACROS_SVH
`define ISOLATION_FOREST_LEAF_CODE_PACKER_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define IFLCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define IFLCP_NEVER(lbl, cond, msg) \
    `IFLCP_ASSERT(lbl, !(cond), msg)

`endif

[rtl/iflcp_pkg.sv]
package iflcp_pkg;

    localparam int MAX_TREES      = 64;
    localparam int NODES_PER_TREE = 512;
    localparam int FEATURES       = 128;
    localparam int DEPTH_LIMIT    = 8;

    localparam int TREE_W  = 6;
    localparam int NODE_W  = 9;
    localparam int FEAT_W  = 7;
    localparam int DEPTH_W = 4;

    // Configuration register indexes.
    localparam logic REG_TREE_COUNT = 1'b0;
    localparam logic REG_PACK_MODE  = 1'b1;

    // Packing modes.
    localparam logic [1:0] PACK_BYTE   = 2'd0;
    localparam logic [1:0] PACK_NIBBLE = 2'd1;
    localparam logic [1:0] PACK_PAIR   = 2'd2;
    localparam logic [1:0] PACK_BIT    = 2'd3;

    // One stored tree node.
    typedef struct packed {
        logic               is_leaf;
        logic [FEAT_W-1:0]  test_feature;
        logic signed [31:0] threshold;
        logic [NODE_W-1:0]  left_child;
        logic [NODE_W-1:0]  right_child;
        logic [7:0]         leaf_label;
    } node_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;       // a transaction is accepted this cycle
        logic eval_init;  // begin a new evaluation
        logic node_rd;    // read the current node
        logic feat_rd;    // read the feature tested by the node
        logic step;       // move to the chosen child
        logic tree_done;  // store the label of the current tree
        logic tree_err;   // the current walk failed
        logic pack_init;  // begin packing
        logic lab_rd;     // read the next label
        logic pack_acc;   // merge the label into the code byte
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic node_leaf;
        logic depth_done;
        logic tree_last;
        logic lab_last;
    } status_t;

endpackage

[rtl/iflcp_ctrl.sv]
`include "isolation_forest_leaf_code_packer_macros.svh"

module iflcp_ctrl
    import iflcp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    kind,
    input  logic    last_feature,
    input  status_t status,
    output logic    busy,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NODE = 3'd1;
    localparam logic [2:0] S_NCHK = 3'd2;
    localparam logic [2:0] S_FCHK = 3'd3;
    localparam logic [2:0] S_PRD  = 3'd4;
    localparam logic [2:0] S_PACC = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take = start;
                if (start && kind && last_feature)
                begin
                    cmd.eval_init = 1'b1;
                    state_next    = S_NODE;
                end
            end
            S_NODE:
            begin
                cmd.node_rd = 1'b1;
                state_next  = S_NCHK;
            end
            S_NCHK:
            begin
                if (status.node_leaf || status.depth_done)
                begin
                    cmd.tree_done = 1'b1;
                    cmd.tree_err  = !status.node_leaf;
                    if (status.tree_last)
                    begin
                        cmd.pack_init = 1'b1;
                        state_next    = S_PRD;
                    end
                    else
                    begin
                        state_next = S_NODE;
                    end
                end
                else
                begin
                    cmd.feat_rd = 1'b1;
                    state_next  = S_FCHK;
                end
            end
            S_FCHK:
            begin
                cmd.step   = 1'b1;
                state_next = S_NODE;
            end
            S_PRD:
            begin
                cmd.lab_rd = 1'b1;
                state_next = S_PACC;
            end
            S_PACC:
            begin
                cmd.pack_acc = 1'b1;
                state_next   = status.lab_last ? S_IDLE : S_PRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // An evaluation start always leaves the idle state.
    `IFLCP_ASSERT(a_eval_busy, cmd.eval_init |=> busy, "evaluation did not start")
    // A feature compare always follows a node check.
    `IFLCP_ASSERT(a_fchk_order, state_reg == S_FCHK |-> $past(state_reg) == S_NCHK, "bad walk order")

endmodule

[rtl/iflcp_datapath.sv]
`include "isolation_forest_leaf_code_packer_macros.svh"

module iflcp_datapath
    import iflcp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [6:0]            cfg_data,
    input  logic                  kind,
    input  logic [TREE_W-1:0]     tree_index,
    input  logic [NODE_W-1:0]     node_index,
    input  logic                  is_leaf,
    input  logic [FEAT_W-1:0]     test_feature,
    input  logic signed [31:0]    threshold,
    input  logic [NODE_W-1:0]     left_child,
    input  logic [NODE_W-1:0]     right_child,
    input  logic [7:0]            leaf_label,
    input  logic [FEAT_W-1:0]     feature_index,
    input  logic signed [31:0]    feature_value,
    output logic                  code_valid,
    output logic [7:0]            code_byte,
    output logic [5:0]            byte_position,
    output logic                  last_byte,
    output logic                  walk_error
);

    node_t              node_mem [MAX_TREES*NODES_PER_TREE];
    logic signed [31:0] feat_mem [FEATURES];
    logic [7:0]         label_mem [MAX_TREES];

    logic [6:0]          tree_count_reg;
    logic [1:0]          pack_mode_reg;
    node_t               node_rd_reg;
    logic signed [31:0]  feat_rd_reg;
    logic [7:0]          label_rd_reg;
    logic [TREE_W-1:0]   tree_reg;
    logic [NODE_W-1:0]   node_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    logic                err_reg;
    logic [5:0]          lab_reg;
    logic [7:0]          acc_reg;
    logic                code_valid_reg;
    logic [7:0]          code_byte_reg;
    logic [5:0]          byte_position_reg;
    logic                last_byte_reg;
    logic                walk_error_reg;

    logic [5:0]          tlast;
    logic [2:0]          sub;
    logic                group_end;
    logic [7:0]          field;
    logic [7:0]          acc_next;
    logic [5:0]          pos;
    logic [NODE_W-1:0]   child;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_count_reg <= 7'd64;
            pack_mode_reg  <= PACK_BYTE;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_TREE_COUNT)
            begin
                tree_count_reg <= cfg_data;
            end
            else if (cfg_index == REG_PACK_MODE)
            begin
                pack_mode_reg <= cfg_data[1:0];
            end
        end
    end

    // Index of the last tree: a count of zero acts as one, larger counts saturate.
    always_comb
    begin
        if (tree_count_reg == 7'd0)
        begin
            tlast = 6'd0;
        end
        else if (tree_count_reg > 7'(MAX_TREES))
        begin
            tlast = 6'(MAX_TREES - 1);
        end
        else
        begin
            tlast = 6'(tree_count_reg - 7'd1);
        end
    end

    // Node table: written by node transactions, read during the walk.
    always_ff @(posedge clk)
    begin
        if (cmd.take && !kind)
        begin
            node_mem[{tree_index, node_index}] <= '{is_leaf, test_feature, threshold,
                                                    left_child, right_child, leaf_label};
        end
        if (cmd.node_rd)
        begin
            node_rd_reg <= node_mem[{tree_reg, node_reg}];
        end
    end

    // Sample features; the feature index always falls inside the store.
    always_ff @(posedge clk)
    begin
        if (cmd.take && kind)
        begin
            feat_mem[feature_index] <= feature_value;
        end
        if (cmd.feat_rd)
        begin
            feat_rd_reg <= feat_mem[node_rd_reg.test_feature];
        end
    end

    // Labels of the walked trees.
    always_ff @(posedge clk)
    begin
        if (cmd.tree_done)
        begin
            label_mem[tree_reg] <= cmd.tree_err ? 8'd0 : node_rd_reg.leaf_label;
        end
        if (cmd.lab_rd)
        begin
            label_rd_reg <= label_mem[lab_reg];
        end
    end

    // Left when the feature is below the threshold; children always fit in a tree.
    assign child = (feat_rd_reg < node_rd_reg.threshold) ? node_rd_reg.left_child
                                                         : node_rd_reg.right_child;

    // Walk position and error flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_reg  <= '0;
            node_reg  <= '0;
            depth_reg <= '0;
            err_reg   <= 1'b0;
        end
        else if (cmd.eval_init)
        begin
            tree_reg  <= '0;
            node_reg  <= '0;
            depth_reg <= '0;
            err_reg   <= 1'b0;
        end
        else if (cmd.tree_done)
        begin
            tree_reg  <= tree_reg + 1'b1;
            node_reg  <= '0;
            depth_reg <= '0;
            err_reg   <= err_reg | cmd.tree_err;
        end
        else if (cmd.step)
        begin
            node_reg  <= child;
            depth_reg <= depth_reg + 1'b1;
        end
    end

    assign status.node_leaf  = node_rd_reg.is_leaf;
    assign status.depth_done = (depth_reg >= DEPTH_W'(DEPTH_LIMIT));
    assign status.tree_last  = (tree_reg == tlast);
    assign status.lab_last   = (lab_reg == tlast);

    // Place of the current label within its code byte.
    always_comb
    begin
        case (pack_mode_reg)
            PACK_BYTE:
            begin
                sub       = 3'd0;
                group_end = 1'b1;
                field     = label_rd_reg;
                pos       = lab_reg;
            end
            PACK_NIBBLE:
            begin
                sub       = {2'd0, lab_reg[0]};
                group_end = lab_reg[0];
                field     = {label_rd_reg[3:0], 4'd0} >> {lab_reg[0], 2'd0};
                pos       = lab_reg >> 1;
            end
            PACK_PAIR:
            begin
                sub       = {1'b0, lab_reg[1:0]};
                group_end = &lab_reg[1:0];
                field     = {label_rd_reg[1:0], 6'd0} >> {lab_reg[1:0], 1'b0};
                pos       = lab_reg >> 2;
            end
            default:
            begin
                sub       = lab_reg[2:0];
                group_end = &lab_reg[2:0];
                field     = 8'(label_rd_reg != 8'd0) << lab_reg[2:0];
                pos       = lab_reg >> 3;
            end
        endcase
        acc_next = ((sub == 3'd0) ? 8'd0 : acc_reg) | field;
    end

    // Packing counter, accumulator and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lab_reg        <= '0;
            acc_reg        <= '0;
            code_valid_reg <= 1'b0;
        end
        else
        begin
            code_valid_reg <= 1'b0;
            if (cmd.pack_init)
            begin
                lab_reg <= '0;
            end
            else if (cmd.pack_acc)
            begin
                lab_reg <= lab_reg + 1'b1;
                acc_reg <= acc_next;
                if (group_end || status.lab_last)
                begin
                    code_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.pack_acc)
        begin
            code_byte_reg     <= acc_next;
            byte_position_reg <= pos;
            last_byte_reg     <= status.lab_last;
            walk_error_reg    <= err_reg;
        end
    end

    assign code_valid    = code_valid_reg;
    assign code_byte     = code_byte_reg;
    assign byte_position = byte_position_reg;
    assign last_byte     = last_byte_reg;
    assign walk_error    = walk_error_reg;

    // The final byte of a code is never followed at once by another code byte.
    `IFLCP_ASSERT(a_last_gap, code_valid && last_byte |=> !code_valid, "byte after last")
    // The walk never reads a node past the depth limit.
    `IFLCP_NEVER(a_depth, cmd.node_rd && depth_reg > DEPTH_W'(DEPTH_LIMIT), "depth overrun")

endmodule

[rtl/isolation_forest_leaf_code_packer.sv]
// An evaluation is accepted while idle; per tree it reads and checks a node, plus a feature
// read and a step per internal level walked (at most 8), then packs the labels; a code byte
// is registered out as soon as packed. Node and plain feature transactions are taken only
// while idle; an evaluation holds busy for the walk and packing.
// Reset clears the controller, counters and result strobe, and sets 64 trees, byte packing.
// The result receiver cannot stall; each byte is shown for one cycle.
module isolation_forest_leaf_code_packer
    import iflcp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               kind,
    input  logic [5:0]         tree_index,
    input  logic [8:0]         node_index,
    input  logic               is_leaf,
    input  logic [6:0]         test_feature,
    input  logic signed [31:0] threshold,
    input  logic [8:0]         left_child,
    input  logic [8:0]         right_child,
    input  logic [7:0]         leaf_label,
    input  logic [6:0]         feature_index,
    input  logic signed [31:0] feature_value,
    input  logic               last_feature,
    output logic               code_valid,
    output logic [7:0]         code_byte,
    output logic [5:0]         byte_position,
    output logic               last_byte,
    output logic               walk_error
);

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    iflcp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .last_feature (last_feature),
        .status       (status),
        .busy         (busy),
        .cmd          (cmd)
    );

    // Memories, walk and packing.
    iflcp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .tree_index    (tree_index),
        .node_index    (node_index),
        .is_leaf       (is_leaf),
        .test_feature  (test_feature),
        .threshold     (threshold),
        .left_child    (left_child),
        .right_child   (right_child),
        .leaf_label    (leaf_label),
        .feature_index (feature_index),
        .feature_value (feature_value),
        .code_valid    (code_valid),
        .code_byte     (code_byte),
        .byte_position (byte_position),
        .last_byte     (last_byte),
        .walk_error    (walk_error)
    );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import iflcp_pkg::*;

    // One input transaction.
    typedef struct {
        logic               kind;
        logic [5:0]         tree_index;
        logic [8:0]         node_index;
        logic               is_leaf;
        logic [6:0]         test_feature;
        logic signed [31:0] threshold;
        logic [8:0]         left_child;
        logic [8:0]         right_child;
        logic [7:0]         leaf_label;
        logic [6:0]         feature_index;
        logic signed [31:0] feature_value;
        logic               last_feature;
    } item_t;

    // One code byte as it should leave the block.
    typedef struct {
        logic [7:0] code;
        logic [5:0] pos;
        logic       last;
        logic       err;
    } code_t;

    // A directed row, with a typed-in single-byte result where one is given.
    typedef struct {
        item_t      it;
        bit         has_exp;
        logic [7:0] exp_code;
        logic       exp_err;
    } row_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 60;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               cfg_write = 1'b0;
    logic               cfg_index = 1'b0;
    logic [6:0]         cfg_data = '0;
    logic               kind = 1'b0;
    logic [5:0]         tree_index = '0;
    logic [8:0]         node_index = '0;
    logic               is_leaf = 1'b0;
    logic [6:0]         test_feature = '0;
    logic signed [31:0] threshold = '0;
    logic [8:0]         left_child = '0;
    logic [8:0]         right_child = '0;
    logic [7:0]         leaf_label = '0;
    logic [6:0]         feature_index = '0;
    logic signed [31:0] feature_value = '0;
    logic               last_feature = 1'b0;
    logic               code_valid;
    logic [7:0]         code_byte;
    logic [5:0]         byte_position;
    logic               last_byte;
    logic               walk_error;

    // Shadow copy of the forest, the sample and the registers.
    node_t              forest [MAX_TREES][NODES_PER_TREE];
    bit                 node_known [MAX_TREES][NODES_PER_TREE];
    logic signed [31:0] sample [FEATURES];
    bit                 feat_known [FEATURES];
    logic [6:0]         trees_reg;
    logic [1:0]         packing_reg;

    code_t code_q [$];
    int    fails = 0;
    int    idle_cycles = 0;
    int    random_items = 0;
    bit    override_next = 1'b0;
    row_t  override_row;
    row_t  dir [$];

    isolation_forest_leaf_code_packer uut (.*);

    always #1 clk = ~clk;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fails++;
    endtask

    // Compare each code byte with the oldest expected one.
    always @(posedge clk) begin
        code_t e;
        if (rst_n && code_valid) begin
            if (code_q.size() == 0) begin
                report("unexpected byte", int'(code_byte), 0);
            end
            else begin
                e = code_q.pop_front();
                if (code_byte !== e.code)
                    report("code_byte", int'(code_byte), int'(e.code));
                if (byte_position !== e.pos)
                    report("byte_position", int'(byte_position), int'(e.pos));
                if (last_byte !== e.last)
                    report("last_byte", int'(last_byte), int'(e.last));
                if (walk_error !== e.err)
                    report("walk_error", int'(walk_error), int'(e.err));
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk) begin
        if (rst_n && ((start && !busy) || code_valid)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Walk one tree of the shadow forest; raises err on a failed walk.
    function automatic logic [7:0] walk_label(input int tr, inout logic err);
        int    nd;
        node_t n;
        nd = 0;
        for (int step = 0; ; step++) begin
            n = forest[tr][nd];
            if (n.is_leaf) return n.leaf_label;
            if (step >= DEPTH_LIMIT) break;
            if (sample[n.test_feature] < n.threshold) nd = int'(n.left_child);
            else nd = int'(n.right_child);
        end
        err = 1'b1;
        return 8'h00;
    endfunction

    function automatic int trees_used();
        int t;
        t = int'(trees_reg);
        if (t < 1) t = 1;
        if (t > MAX_TREES) t = MAX_TREES;
        return t;
    endfunction

    // Work out the packed code of the current sample.
    task automatic predict_code();
        logic [7:0] labels [MAX_TREES];
        logic       err;
        int         t, nbytes;
        code_t      c;
        t = trees_used();
        err = 1'b0;
        for (int k = 0; k < t; k++) labels[k] = walk_label(k, err);
        case (packing_reg)
            PACK_BYTE:   nbytes = t;
            PACK_NIBBLE: nbytes = (t + 1) / 2;
            PACK_PAIR:   nbytes = (t + 3) / 4;
            default:     nbytes = (t + 7) / 8;
        endcase
        for (int b = 0; b < nbytes; b++) begin
            c.code = 8'h00;
            case (packing_reg)
                PACK_BYTE: c.code = labels[b];
                PACK_NIBBLE:
                    for (int k = 0; k < 2 && b * 2 + k < t; k++)
                        c.code |= (labels[b * 2 + k] & 8'h0F) << (4 - 4 * k);
                PACK_PAIR:
                    for (int k = 0; k < 4 && b * 4 + k < t; k++)
                        c.code |= (labels[b * 4 + k] & 8'h03) << (6 - 2 * k);
                default:
                    for (int k = 0; k < 8 && b * 8 + k < t; k++)
                        if (labels[b * 8 + k] != 0) c.code |= 8'h01 << k;
            endcase
            c.pos = b[5:0];
            c.last = (b + 1 == nbytes);
            c.err = err;
            code_q = {code_q, c};
        end
    endtask

    // Update the shadow state for an accepted transaction.
    task automatic absorb(input item_t it);
        node_t n;
        code_t c;
        if (it.kind == 1'b0) begin
            n.is_leaf = it.is_leaf;
            n.test_feature = it.test_feature;
            n.threshold = it.threshold;
            n.left_child = it.left_child;
            n.right_child = it.right_child;
            n.leaf_label = it.leaf_label;
            forest[it.tree_index][it.node_index] = n;
            node_known[it.tree_index][it.node_index] = 1'b1;
        end
        else begin
            sample[it.feature_index] = it.feature_value;
            feat_known[it.feature_index] = 1'b1;
            if (it.last_feature) begin
                if (override_next) begin
                    c.code = override_row.exp_code;
                    c.pos = '0;
                    c.last = 1'b1;
                    c.err = override_row.exp_err;
                    code_q = {code_q, c};
                end
                else begin
                    predict_code();
                end
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70) return 0;
        if (r < 95) return int'($urandom_range(1, 4));
        return int'($urandom_range(20, 80));
    endfunction

    // Present one transaction, wait for it to be taken, then maybe pause.
    task automatic send(input item_t it);
        int gap;
        @(negedge clk);
        kind <= it.kind;
        tree_index <= it.tree_index;
        node_index <= it.node_index;
        is_leaf <= it.is_leaf;
        test_feature <= it.test_feature;
        threshold <= it.threshold;
        left_child <= it.left_child;
        right_child <= it.right_child;
        leaf_label <= it.leaf_label;
        feature_index <= it.feature_index;
        feature_value <= it.feature_value;
        last_feature <= it.last_feature;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        absorb(it);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Wait until every expected byte has come and the block has settled.
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        do @(posedge clk); while (busy || code_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_TREE_COUNT) trees_reg = data;
        else packing_reg = data[1:0];
    endtask

    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t node_item(input int tr, input int nd, input bit wide);
        item_t it;
        it.kind = 1'b0;
        it.tree_index = tr[5:0];
        it.node_index = nd[8:0];
        it.is_leaf = ($urandom_range(0, 99) < 45);
        it.test_feature = ($urandom_range(0, 99) < 80) ? 7'($urandom_range(0, 15))
                                                      : 7'($urandom);
        it.threshold = rand_q16();
        it.left_child = wide ? 9'($urandom) : 9'($urandom_range(0, 15));
        it.right_child = wide ? 9'($urandom) : 9'($urandom_range(0, 15));
        it.leaf_label = 8'($urandom);
        it.feature_index = 7'($urandom);
        it.feature_value = $urandom;
        it.last_feature = 1'($urandom);
        return it;
    endfunction

    function automatic item_t feat_item(input int idx, input logic signed [31:0] val,
                                        input bit last);
        item_t it;
        it = node_item($urandom, $urandom, 1'b1);
        it.kind = 1'b1;
        it.feature_index = idx[6:0];
        it.feature_value = val;
        it.last_feature = last;
        return it;
    endfunction

    // Find the first entry that an evaluation would read before it is written.
    function automatic bit find_hole(output bit is_node, output int tr, output int nd,
                                     output int ft);
        node_t n;
        int    cur;
        is_node = 1'b0;
        tr = 0;
        nd = 0;
        ft = 0;
        for (int k = 0; k < trees_used(); k++) begin
            cur = 0;
            for (int step = 0; step <= DEPTH_LIMIT; step++) begin
                if (!node_known[k][cur]) begin
                    is_node = 1'b1;
                    tr = k;
                    nd = cur;
                    return 1'b1;
                end
                n = forest[k][cur];
                if (n.is_leaf || step == DEPTH_LIMIT) break;
                if (!feat_known[n.test_feature]) begin
                    ft = int'(n.test_feature);
                    return 1'b1;
                end
                cur = (sample[n.test_feature] < n.threshold) ? int'(n.left_child)
                                                             : int'(n.right_child);
            end
        end
        return 1'b0;
    endfunction

    // Write whatever the next evaluation would read that is still unwritten.
    task automatic fill_holes();
        bit is_node;
        int tr, nd, ft;
        while (find_hole(is_node, tr, nd, ft)) begin
            if (is_node) send(node_item(tr, nd, $urandom_range(0, 9) == 0));
            else send(feat_item(ft, rand_q16(), 1'b0));
            random_items++;
        end
    endtask

    // Directed row helpers.
    task automatic add_node(input int tr, input int nd, input bit leaf, input int ft,
                            input logic signed [31:0] thr, input int lc, input int rc,
                            input logic [7:0] label);
        row_t r;
        r.it = node_item(tr, nd, 1'b0);
        r.it.is_leaf = leaf;
        r.it.test_feature = ft[6:0];
        r.it.threshold = thr;
        r.it.left_child = lc[8:0];
        r.it.right_child = rc[8:0];
        r.it.leaf_label = label;
        r.has_exp = 1'b0;
        dir = {dir, r};
    endtask

    task automatic add_feat(input int idx, input logic signed [31:0] val, input bit last,
                            input bit has_exp, input logic [7:0] code, input logic err);
        row_t r;
        r.it = feat_item(idx, val, last);
        r.has_exp = has_exp;
        r.exp_code = code;
        r.exp_err = err;
        dir = {dir, r};
    endtask

    initial begin
        logic [6:0] tree_set [8];
        logic [1:0] pack_set [8];
        int  phase_items, r, idx;
        logic signed [31:0] val;

        tree_set = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd17, 7'd40, 7'd64};
        pack_set = '{PACK_BIT, PACK_BYTE, PACK_NIBBLE, PACK_PAIR,
                     PACK_BIT, PACK_NIBBLE, PACK_PAIR, PACK_BIT};
        trees_reg = 7'd64;
        packing_reg = PACK_BYTE;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: one tree, one byte per tree, so results are read off directly.
        write_reg(REG_TREE_COUNT, 7'd1);
        write_reg(REG_PACK_MODE, {5'd0, PACK_BYTE});
        add_node(0, 0, 1'b0, 127, 32'sh8000_0000, 1, 2, 8'h11);
        add_node(0, 1, 1'b1, 0, 32'sh0, 0, 0, 8'h00);
        add_node(0, 2, 1'b1, 0, 32'sh0, 0, 0, 8'hFF);
        add_node(63, 511, 1'b1, 127, 32'sh7FFF_FFFF, 511, 511, 8'h80);
        add_feat(127, 32'sh7FFF_FFFF, 1'b0, 1'b0, 8'h00, 1'b0);
        add_feat(0, 32'sh0000_0000, 1'b1, 1'b1, 8'hFF, 1'b0);
        // Feature equal to the threshold goes right.
        add_feat(127, 32'sh8000_0000, 1'b1, 1'b1, 8'hFF, 1'b0);
        add_node(0, 0, 1'b0, 127, 32'sh7FFF_FFFF, 1, 2, 8'h00);
        add_feat(127, 32'sh8000_0000, 1'b1, 1'b1, 8'h00, 1'b0);
        add_feat(127, 32'sh7FFF_FFFF, 1'b1, 1'b1, 8'hFF, 1'b0);
        // A node that loops on itself exhausts the depth.
        add_node(0, 0, 1'b0, 0, 32'sh0000_0000, 0, 0, 8'h00);
        add_feat(0, 32'sh0000_0001, 1'b1, 1'b1, 8'h00, 1'b1);
        add_node(0, 0, 1'b1, 0, 32'sh0, 3, 3, 8'h5A);
        add_feat(5, 32'sh1234_5678, 1'b1, 1'b1, 8'h5A, 1'b0);
        // Walk of full depth that ends on a leaf at the last level.
        for (int d = 0; d < DEPTH_LIMIT; d++)
            add_node(0, 100 + d, 1'b0, 1, 32'sh0, 0, 101 + d, 8'h00);
        add_node(0, 108, 1'b1, 0, 32'sh0, 0, 0, 8'hC3);
        add_node(0, 0, 1'b0, 1, 32'sh0, 0, 101, 8'h00);
        add_feat(1, 32'sh0000_0000, 1'b1, 1'b0, 8'h00, 1'b0);
        foreach (dir[i]) begin
            override_next = dir[i].has_exp;
            override_row = dir[i];
            send(dir[i].it);
        end
        override_next = 1'b0;

        // Random part: a phase per register setting, mostly well-formed evaluations.
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            write_reg(REG_TREE_COUNT, tree_set[p]);
            write_reg(REG_PACK_MODE, {5'($urandom_range(0, 31)), pack_set[p]});
            phase_items = random_items;
            while (random_items - phase_items < 45) begin
                r = int'($urandom_range(0, 99));
                if (r < 12) begin
                    send(node_item($urandom, $urandom, 1'b1));
                    random_items++;
                end
                else if (r < 30) begin
                    send(feat_item($urandom_range(0, 127), rand_q16(), 1'b0));
                    random_items++;
                end
                else if (r < 50) begin
                    send(node_item($urandom_range(0, trees_used() - 1),
                                   $urandom_range(0, 15), $urandom_range(0, 9) == 0));
                    random_items++;
                end
                else begin
                    // Settle the closing feature first so the walk is known ahead.
                    idx = ($urandom_range(0, 99) < 70) ? int'($urandom_range(0, 15))
                                                       : int'($urandom_range(0, 127));
                    val = rand_q16();
                    sample[idx] = val;
                    feat_known[idx] = 1'b1;
                    fill_holes();
                    send(feat_item(idx, val, 1'b1));
                    random_items++;
                end
            end
        end

        // Drain and conclude.
        wait_idle();
        repeat (100) @(posedge clk);
        if (code_q.size() != 0) report("bytes never seen", code_q.size(), 0);
        if (fails == 0) begin
            $display("CHECK OK");
        end
        else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
